FILE: design/dwq_pkg.sv
// Shared types and constants for the deduplicating worklist queue.
`default_nettype none

package dwq_pkg;

  localparam int CMD_W     = 2;
  localparam int VERTEX_W  = 10;
  localparam int VCOUNT_W  = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 16;
  localparam int RESULT_W  = VERTEX_W + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_TAKE    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_BACKWARD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIFO_MODE     = 2'd2;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;

endpackage

`default_nettype wire

FILE: design/dedup_worklist_queue.sv
// Top level of the deduplicating worklist queue: mark bitmap, ring memory, sequencer.
//
//  channel  dir  handshake              payload
//  s        in   s_tvalid / s_tready    s_tuser = command, s_tdata = vertex
//  m        out  m_tvalid / m_tready    m_tdata = taken_vertex, queue_empty, accepted
//  cfg      in   cfg_we                 cfg_index, cfg_data
//
// Enqueue, take and no-op each run a read step (enqueue reads the mark memory, take
// the ring memory), then a write-back step that writes back and loads the result
// register. Restart sweeps both memories one entry a cycle, then gives its result;
// reset runs the same sweep (no result) with s_tready low. A result waiting on
// m_tready holds the sequencer in its write-back step.
`default_nettype none

module dedup_worklist_queue
  import dwq_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // [9:0] vertex
  input  wire logic [CMD_W-1:0]     s_tuser,   // [1:0] command
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata    // [9:0] taken_vertex, [10] queue_empty,
                                               // [11] accepted
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CAP_W = $clog2(MAX_VERTICES + 1);

  logic                mark_we;
  logic [IDX_W-1:0]    mark_waddr;
  logic                mark_wdata;
  logic                mark_re;
  logic [IDX_W-1:0]    mark_raddr;
  logic                mark_rdata;
  logic                ring_we;
  logic [IDX_W-1:0]    ring_waddr;
  logic [IDX_W-1:0]    ring_wdata;
  logic                ring_re;
  logic [IDX_W-1:0]    ring_raddr;
  logic [IDX_W-1:0]    ring_rdata;
  logic [RESULT_W-1:0] result;

  dwq_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .IDX_W        (IDX_W),
    .CAP_W        (CAP_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_cmd      (s_tuser),
    .s_vertex   (s_tdata[VERTEX_W-1:0]),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_result   (result),
    .mark_we    (mark_we),
    .mark_waddr (mark_waddr),
    .mark_wdata (mark_wdata),
    .mark_re    (mark_re),
    .mark_raddr (mark_raddr),
    .mark_rdata (mark_rdata),
    .ring_we    (ring_we),
    .ring_waddr (ring_waddr),
    .ring_wdata (ring_wdata),
    .ring_re    (ring_re),
    .ring_raddr (ring_raddr),
    .ring_rdata (ring_rdata)
  );

  dwq_ram #(
    .W     (1),
    .DEPTH (MAX_VERTICES)
  ) u_marks (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (mark_re),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

  dwq_ram #(
    .W     (IDX_W),
    .DEPTH (MAX_VERTICES)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  assign m_tdata = {{(M_TDATA_W - RESULT_W){1'b0}}, result};

endmodule

`default_nettype wire

FILE: design/dwq_ram.sv
// Simple dual-port synchronous RAM with registered read.
`default_nettype none

module dwq_ram #(
  parameter int W     = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/dwq_ctrl.sv
// Sequencer: configuration, ring pointers, memory access and result register.
`default_nettype none

module dwq_ctrl
  import dwq_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int IDX_W        = $clog2(MAX_VERTICES),
  parameter int CAP_W        = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [CMD_W-1:0]     s_cmd,
  input  wire logic [VERTEX_W-1:0]  s_vertex,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [RESULT_W-1:0]       m_result,
  output logic                      mark_we,
  output logic [IDX_W-1:0]          mark_waddr,
  output logic                      mark_wdata,
  output logic                      mark_re,
  output logic [IDX_W-1:0]          mark_raddr,
  input  wire logic                 mark_rdata,
  output logic                      ring_we,
  output logic [IDX_W-1:0]          ring_waddr,
  output logic [IDX_W-1:0]          ring_wdata,
  output logic                      ring_re,
  output logic [IDX_W-1:0]          ring_raddr,
  input  wire logic [IDX_W-1:0]     ring_rdata
);

  localparam int CMP_W  = (CAP_W > VCOUNT_W) ? CAP_W : VCOUNT_W;
  localparam int VCMP_W = (CAP_W > VERTEX_W) ? CAP_W : VERTEX_W;
  localparam int RESET_CAP_I = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
  localparam logic [CAP_W-1:0] RESET_CAP = CAP_W'(RESET_CAP_I);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_VERTICES - 1);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t              state;
  logic [VCOUNT_W-1:0] vertex_count;
  logic                fill_backward;
  logic                lifo_mode;
  logic [CAP_W-1:0]    cap;
  logic [IDX_W-1:0]    head;
  logic [IDX_W-1:0]    tail;
  logic [CAP_W-1:0]    count;
  cmd_t                cmd_q;
  logic [VERTEX_W-1:0] v_q;
  logic                empty_q;
  logic                sweep_back;
  logic                sweep_reply;
  logic [IDX_W-1:0]    sw_idx;
  logic [VERTEX_W-1:0] out_taken;
  logic                out_empty;
  logic                out_acc;

  logic [CMP_W-1:0]    vc_ext;
  logic [CAP_W-1:0]    cap_cfg;
  logic                slot_free;
  logic                in_fire;
  cmd_t                in_cmd;
  logic                enq_ok;
  logic                fin;
  logic [CAP_W-1:0]    head_inc;
  logic [IDX_W-1:0]    head_next;
  logic [CAP_W-1:0]    tail_base;
  logic [IDX_W-1:0]    tail_dec;
  logic [CAP_W-1:0]    tail_inc;
  logic [IDX_W-1:0]    tail_next;
  logic [CAP_W-1:0]    sw_ext;
  logic [IDX_W-1:0]    sw_fill;

  // clamp the vertex count into one..MAX_VERTICES
  always_comb begin
    vc_ext = CMP_W'(vertex_count);
    if (vc_ext == '0) begin
      cap_cfg = CAP_W'(1);
    end else if (vc_ext > CMP_W'(MAX_VERTICES)) begin
      cap_cfg = CAP_W'(MAX_VERTICES);
    end else begin
      cap_cfg = CAP_W'(vc_ext);
    end
  end

  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign in_cmd    = cmd_t'(s_cmd);
  assign slot_free = !m_tvalid || m_tready;
  assign fin       = (state == ST_EXEC) && slot_free;

  assign enq_ok = (VCMP_W'(v_q) < VCMP_W'(cap)) && (VCMP_W'(v_q) < VCMP_W'(MAX_VERTICES))
                  && !mark_rdata && (count < cap) && (CAP_W'(tail) < cap);

  // pointer arithmetic
  always_comb begin
    head_inc  = CAP_W'(head) + CAP_W'(1);
    head_next = (head_inc >= cap) ? '0 : IDX_W'(head_inc);
    tail_base = ((tail == '0) || (CAP_W'(tail) > cap)) ? cap : CAP_W'(tail);
    tail_dec  = IDX_W'(tail_base - CAP_W'(1));
    tail_inc  = CAP_W'(tail) + CAP_W'(1);
    tail_next = (tail_inc >= cap) ? '0 : IDX_W'(tail_inc);
    sw_ext    = CAP_W'(sw_idx);
    sw_fill   = sweep_back ? IDX_W'(cap - CAP_W'(1) - sw_ext) : sw_idx;
  end

  // memory ports
  always_comb begin
    mark_re    = in_fire && (in_cmd == CMD_ENQUEUE);
    mark_raddr = IDX_W'(s_vertex);
    ring_re    = in_fire && (in_cmd == CMD_TAKE);
    ring_raddr = lifo_mode ? tail_dec : head;
    mark_we    = 1'b0;
    mark_waddr = sw_idx;
    mark_wdata = 1'b0;
    ring_we    = 1'b0;
    ring_waddr = sw_idx;
    ring_wdata = sw_idx;
    if (state == ST_SWEEP) begin
      mark_we    = 1'b1;
      mark_wdata = (sw_ext < cap);
      ring_we    = 1'b1;
      ring_wdata = (sw_ext < cap) ? sw_fill : sw_idx;
    end else if (fin && (cmd_q == CMD_ENQUEUE) && enq_ok) begin
      mark_we    = 1'b1;
      mark_waddr = IDX_W'(v_q);
      mark_wdata = 1'b1;
      ring_we    = 1'b1;
      ring_waddr = tail;
      ring_wdata = IDX_W'(v_q);
    end else if (fin && (cmd_q == CMD_TAKE) && !empty_q) begin
      // release the mark of the vertex just taken
      mark_we    = 1'b1;
      mark_waddr = ring_rdata;
      mark_wdata = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      vertex_count  <= VCOUNT_RESET;
      fill_backward <= 1'b0;
      lifo_mode     <= 1'b0;
      cap           <= RESET_CAP;
      head          <= '0;
      tail          <= '0;
      count         <= RESET_CAP;
      sweep_back    <= 1'b0;
      sweep_reply   <= 1'b0;
      sw_idx        <= '0;
      m_tvalid      <= 1'b0;
      cmd_q         <= CMD_NOP;
      empty_q       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_VERTEX_COUNT:  vertex_count  <= cfg_data[VCOUNT_W-1:0];
          REG_FILL_BACKWARD: fill_backward <= cfg_data[0];
          REG_LIFO_MODE:     lifo_mode     <= cfg_data[0];
          default: ;
        endcase
      end

      if (fin) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_SWEEP: begin
          if (sw_idx == LAST_IDX) begin
            sw_idx <= '0;
            state  <= sweep_reply ? ST_EXEC : ST_IDLE;
          end else begin
            sw_idx <= sw_idx + IDX_W'(1);
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            cmd_q   <= in_cmd;
            v_q     <= s_vertex;
            empty_q <= (count == '0);
            if (in_cmd == CMD_RESTART) begin
              // latch the geometry for the whole sweep
              cap         <= cap_cfg;
              count       <= cap_cfg;
              head        <= '0;
              tail        <= '0;
              sweep_back  <= fill_backward;
              sweep_reply <= 1'b1;
              sw_idx      <= '0;
              state       <= ST_SWEEP;
            end else begin
              state <= ST_EXEC;
              if (in_cmd == CMD_TAKE && count != '0) begin
                count <= count - CAP_W'(1);
                if (lifo_mode) begin
                  tail <= tail_dec;
                end else begin
                  head <= head_next;
                end
              end
            end
          end
        end
        ST_EXEC: begin
          if (slot_free) begin
            out_taken <= ((cmd_q == CMD_TAKE) && !empty_q) ? VERTEX_W'(ring_rdata) : '0;
            out_empty <= (cmd_q == CMD_TAKE) && empty_q;
            out_acc   <= (cmd_q == CMD_ENQUEUE) && enq_ok;
            if ((cmd_q == CMD_ENQUEUE) && enq_ok) begin
              tail  <= tail_next;
              count <= count + CAP_W'(1);
            end
            sweep_reply <= 1'b0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_result = {out_acc, out_empty, out_taken};

endmodule

`default_nettype wire

FILE: test/tb_dedup_worklist_queue.sv
// Self-checking testbench for the deduplicating worklist queue, with its own predictor.
`timescale 1ns / 100ps

module tb_dedup_worklist_queue;
  import dwq_pkg::*;

  localparam int MAX_V       = 1024;
  localparam int STALL_LIMIT = 8192;
  localparam int PHASE_ITEMS = 265;

  typedef struct packed {
    logic                accepted;
    logic                queue_empty;
    logic [VERTEX_W-1:0] taken_vertex;
  } wl_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // [9:0] vertex
  logic [CMD_W-1:0]     s_tuser;   // [1:0] command
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;   // [9:0] taken_vertex, [10] queue_empty, [11] accepted

  dedup_worklist_queue #(.MAX_VERTICES(MAX_V)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: register copies, latched capacity, marks and ring
  int         reg_vcount;
  bit         reg_backward;
  bit         reg_lifo;
  int         cur_cap;
  bit         marks [MAX_V];
  int         ring_slots [MAX_V];
  int         head_ptr;
  int         tail_ptr;
  int         occupancy;

  wl_result_t due_results[$];
  wl_result_t got_result;
  wl_result_t want_result;

  int src_idle_pct;
  int snk_idle_pct;
  int fail_count;
  int result_count;
  int stall_cycles;
  int n_items, n_enq, n_added, n_take, n_empty, n_restart, n_nop, n_cfg;

  // Latch capacity and mark every vertex in use, ring filled ascending or, if backward, descending
  function automatic void refill_worklist();
    int cap;
    cap = reg_vcount;
    if (cap < 1) cap = 1;
    if (cap > MAX_V) cap = MAX_V;
    cur_cap = cap;
    for (int i = 0; i < MAX_V; i++) begin
      marks[i] = (i < cap);
      if (i < cap) begin
        ring_slots[i] = reg_backward ? (cap - 1 - i) : i;
      end else begin
        ring_slots[i] = i;
      end
    end
    head_ptr  = 0;
    tail_ptr  = 0;
    occupancy = cap;
  endfunction

  function automatic wl_result_t apply_command(cmd_t cmd, logic [VERTEX_W-1:0] v);
    wl_result_t r;
    int         got_v;
    r = '0;
    case (cmd)
      CMD_ENQUEUE: begin
        if (int'(v) < cur_cap && !marks[v] && occupancy < cur_cap && tail_ptr < cur_cap) begin
          marks[v] = 1'b1;
          ring_slots[tail_ptr] = v;
          tail_ptr++;
          if (tail_ptr >= cur_cap) tail_ptr = 0;
          occupancy++;
          r.accepted = 1'b1;
        end
      end
      CMD_TAKE: begin
        if (occupancy == 0) begin
          r.queue_empty = 1'b1;
        end else begin
          if (reg_lifo) begin
            if (tail_ptr == 0 || tail_ptr > cur_cap) tail_ptr = cur_cap;
            tail_ptr--;
            got_v = ring_slots[tail_ptr];
          end else begin
            got_v = ring_slots[head_ptr];
            head_ptr++;
            if (head_ptr >= cur_cap) head_ptr = 0;
          end
          occupancy--;
          marks[got_v] = 1'b0;
          r.taken_vertex = got_v[VERTEX_W-1:0];
        end
      end
      CMD_RESTART: refill_worklist();
      default: ;
    endcase
    return r;
  endfunction

  function automatic void log_failure(string msg);
    if (fail_count < 10) $display("ERROR: %s", msg);
    fail_count++;
  endfunction

  // Receiver side: random backpressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_result = wl_result_t'(m_tdata[RESULT_W-1:0]);
      result_count++;
      if (due_results.size() == 0) begin
        log_failure($sformatf("result %0d with nothing outstanding: taken=%0d empty=%0b acc=%0b",
                              result_count, got_result.taken_vertex,
                              got_result.queue_empty, got_result.accepted));
      end else begin
        want_result = due_results.pop_front();
        if (got_result.taken_vertex !== want_result.taken_vertex ||
            got_result.queue_empty !== want_result.queue_empty ||
            got_result.accepted !== want_result.accepted) begin
          log_failure($sformatf({"result %0d: expected taken=%0d empty=%0b acc=%0b, ",
                                 "got taken=%0d empty=%0b acc=%0b"}, result_count,
                                want_result.taken_vertex, want_result.queue_empty,
                                want_result.accepted, got_result.taken_vertex,
                                got_result.queue_empty, got_result.accepted));
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               stall_cycles, due_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_command(input cmd_t cmd, input logic [VERTEX_W-1:0] v);
    wl_result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(S_TDATA_W-VERTEX_W){1'b0}}, v};
    do @(posedge clk); while (!s_tready);
    r = apply_command(cmd, v);
    due_results.push_back(r);
    n_items++;
    case (cmd)
      CMD_ENQUEUE: begin
        n_enq++;
        n_added += r.accepted;
      end
      CMD_TAKE: begin
        n_take++;
        n_empty += r.queue_empty;
      end
      CMD_RESTART: n_restart++;
      default:     n_nop++;
    endcase
  endtask

  // Drop valid and hold until every outstanding result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    case (idx)
      REG_VERTEX_COUNT:  reg_vcount   = val & ((1 << VCOUNT_W) - 1);
      REG_FILL_BACKWARD: reg_backward = val[0];
      REG_LIFO_MODE:     reg_lifo     = val[0];
      default: ;
    endcase
    n_cfg++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_vertex_count();
    case ($urandom_range(9))
      0:       return 1;
      1:       return MAX_V;
      2:       return 2;
      default: return $urandom_range(48, 3);
    endcase
  endfunction

  // Full ascending queue straight out of reset
  task automatic test_reset_fill();
    send_command(CMD_TAKE, 10'd0);
    send_command(CMD_TAKE, 10'd1023);
    send_command(CMD_ENQUEUE, 10'd0);
    send_command(CMD_ENQUEUE, 10'd5);
    send_command(CMD_ENQUEUE, 10'd1023);
    send_command(CMD_NOP, 10'd1023);
  endtask

  // Vertex count zero acts as one, above the maximum acts as the maximum
  task automatic test_capacity_clamp();
    write_reg(REG_VERTEX_COUNT, 0);
    send_command(CMD_RESTART, 10'd0);
    send_command(CMD_TAKE, 10'd0);
    send_command(CMD_TAKE, 10'd0);
    send_command(CMD_ENQUEUE, 10'd1);
    send_command(CMD_ENQUEUE, 10'd0);
    send_command(CMD_ENQUEUE, 10'd0);
    write_reg(REG_VERTEX_COUNT, (1 << VCOUNT_W) - 1);
    send_command(CMD_RESTART, 10'd1023);
    send_command(CMD_TAKE, 10'd0);
  endtask

  task automatic test_backward_stack();
    write_reg(REG_VERTEX_COUNT, 5);
    write_reg(REG_FILL_BACKWARD, 1);
    send_command(CMD_RESTART, 10'd0);
    send_command(CMD_TAKE, 10'd0);
    write_reg(REG_LIFO_MODE, 1);
    send_command(CMD_TAKE, 10'd0);
    send_command(CMD_ENQUEUE, 10'd4);
    send_command(CMD_TAKE, 10'd0);
  endtask

  // New vertex count only applies at the next restart; then drain to empty
  task automatic test_empty_take();
    write_reg(REG_VERTEX_COUNT, 2);
    send_command(CMD_TAKE, 10'd0);
    send_command(CMD_RESTART, 10'd0);
    send_command(CMD_TAKE, 10'd0);
    send_command(CMD_TAKE, 10'd0);
    send_command(CMD_TAKE, 10'd0);
    send_command(CMD_ENQUEUE, 10'd1023);
  endtask

  task automatic test_random_traffic(input int n, input int src_pct, input int snk_pct);
    int   r;
    cmd_t cmd;
    logic [VERTEX_W-1:0] v;
    drain_results();
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    write_reg(REG_VERTEX_COUNT, pick_vertex_count());
    write_reg(REG_FILL_BACKWARD, $urandom_range(1));
    write_reg(REG_LIFO_MODE, $urandom_range(1));
    send_command(CMD_RESTART, VERTEX_W'($urandom));
    for (int i = 1; i < n; i++) begin
      if (i % 64 == 0) begin
        // reconfigure mid-run; count and fill order wait for a restart
        write_reg(REG_LIFO_MODE, $urandom_range(1));
        if ($urandom_range(1)) begin
          write_reg(REG_VERTEX_COUNT, pick_vertex_count());
          write_reg(REG_FILL_BACKWARD, $urandom_range(1));
        end
      end
      r = $urandom_range(99);
      if (r < 46)      cmd = CMD_ENQUEUE;
      else if (r < 88) cmd = CMD_TAKE;
      else if (r < 97) cmd = CMD_NOP;
      else             cmd = CMD_RESTART;
      if (cmd == CMD_ENQUEUE && $urandom_range(99) < 85) begin
        v = VERTEX_W'($urandom_range(cur_cap - 1));
      end else begin
        v = VERTEX_W'($urandom);
      end
      send_command(cmd, v);
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_VERTEX_COUNT;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CMD_NOP;
    src_idle_pct = 22;
    snk_idle_pct = 45;
    reg_vcount   = VCOUNT_RESET;
    reg_backward = 1'b0;
    reg_lifo     = 1'b0;
    refill_worklist();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_fill();
    test_capacity_clamp();
    test_backward_stack();
    test_empty_take();
    test_random_traffic(PHASE_ITEMS, 22, 45);
    test_random_traffic(PHASE_ITEMS, 45, 22);
    test_random_traffic(PHASE_ITEMS, 0, 0);

    drain_results();
    repeat (8) @(posedge clk);
    fail_count += due_results.size();

    $display("Covered %0d commands over %0d register writes: %0d enqueues (%0d added),",
             n_items, n_cfg, n_enq, n_added);
    $display("  %0d takes (%0d on empty), %0d restarts, %0d no-ops; %0d failures",
             n_take, n_empty, n_restart, n_nop, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
